@@ rtl/rthc_pkg.sv @@
// Shared types, constants and the product schedule for the ray/triangle hit counter.
package rthc_pkg;

    localparam int DIGIT_W   = 32;
    localparam int DIG_IDX_W = 3;
    localparam int STEP_W    = 5;
    localparam int CFG_IDX_W = 3;
    localparam int TOL_W     = 16;

    localparam logic [TOL_W-1:0] TOL_RESET = 16'd4;

    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_X    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_Y    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_Z    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TOL      = 3'd6;

    localparam logic [STEP_W-1:0] STEP_FIRST    = 5'd0;
    localparam logic [STEP_W-1:0] STEP_DET_END  = 5'd8;
    localparam logic [STEP_W-1:0] STEP_NU_START = 5'd9;
    localparam logic [STEP_W-1:0] STEP_NT_END   = 5'd23;
    localparam logic [STEP_W-1:0] STEP_LO       = 5'd24;

    typedef enum logic [2:0] {A_DIR, A_E1, A_E2, A_SV, A_TOL} a_grp_t;
    typedef enum logic [2:0] {B_E1, B_E2, B_H, B_Q, B_DET} b_grp_t;
    typedef enum logic [2:0] {D_NONE, D_H, D_Q, D_DET, D_NU, D_NV, D_NT, D_LO} d_grp_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_MUL, ST_ACC, ST_DET, ST_FIX, ST_CHK, ST_DONE
    } state_t;

    typedef struct packed {
        a_grp_t     a_grp;
        logic [1:0] a_idx;
        b_grp_t     b_grp;
        logic [1:0] b_idx;
        logic       neg;
        logic       first;
        d_grp_t     d_grp;
        logic [1:0] d_idx;
    } op_t;

    typedef struct packed {
        logic                 load;
        logic                 mul;
        logic                 top;
        logic [DIG_IDX_W-1:0] dig;
        logic                 acc;
        logic [STEP_W-1:0]    step;
        logic                 fix;
        logic                 chk;
        logic                 miss;
        logic                 emit;
    } cmd_t;

    // h = d x e2, det = e1.h, nu = s.h, q = s x e1, nv = d.q, nt = e2.q, lo = tol*|det|
    function automatic op_t op_of(input logic [STEP_W-1:0] step);
        op_t op;
        case (step)
            5'd0:  op = '{A_DIR, 2'd1, B_E2,  2'd2, 1'b0, 1'b1, D_NONE, 2'd0};
            5'd1:  op = '{A_DIR, 2'd2, B_E2,  2'd1, 1'b1, 1'b0, D_H,    2'd0};
            5'd2:  op = '{A_DIR, 2'd2, B_E2,  2'd0, 1'b0, 1'b1, D_NONE, 2'd0};
            5'd3:  op = '{A_DIR, 2'd0, B_E2,  2'd2, 1'b1, 1'b0, D_H,    2'd1};
            5'd4:  op = '{A_DIR, 2'd0, B_E2,  2'd1, 1'b0, 1'b1, D_NONE, 2'd0};
            5'd5:  op = '{A_DIR, 2'd1, B_E2,  2'd0, 1'b1, 1'b0, D_H,    2'd2};
            5'd6:  op = '{A_E1,  2'd0, B_H,   2'd0, 1'b0, 1'b1, D_NONE, 2'd0};
            5'd7:  op = '{A_E1,  2'd1, B_H,   2'd1, 1'b0, 1'b0, D_NONE, 2'd0};
            5'd8:  op = '{A_E1,  2'd2, B_H,   2'd2, 1'b0, 1'b0, D_DET,  2'd0};
            5'd9:  op = '{A_SV,  2'd0, B_H,   2'd0, 1'b0, 1'b1, D_NONE, 2'd0};
            5'd10: op = '{A_SV,  2'd1, B_H,   2'd1, 1'b0, 1'b0, D_NONE, 2'd0};
            5'd11: op = '{A_SV,  2'd2, B_H,   2'd2, 1'b0, 1'b0, D_NU,   2'd0};
            5'd12: op = '{A_SV,  2'd1, B_E1,  2'd2, 1'b0, 1'b1, D_NONE, 2'd0};
            5'd13: op = '{A_SV,  2'd2, B_E1,  2'd1, 1'b1, 1'b0, D_Q,    2'd0};
            5'd14: op = '{A_SV,  2'd2, B_E1,  2'd0, 1'b0, 1'b1, D_NONE, 2'd0};
            5'd15: op = '{A_SV,  2'd0, B_E1,  2'd2, 1'b1, 1'b0, D_Q,    2'd1};
            5'd16: op = '{A_SV,  2'd0, B_E1,  2'd1, 1'b0, 1'b1, D_NONE, 2'd0};
            5'd17: op = '{A_SV,  2'd1, B_E1,  2'd0, 1'b1, 1'b0, D_Q,    2'd2};
            5'd18: op = '{A_DIR, 2'd0, B_Q,   2'd0, 1'b0, 1'b1, D_NONE, 2'd0};
            5'd19: op = '{A_DIR, 2'd1, B_Q,   2'd1, 1'b0, 1'b0, D_NONE, 2'd0};
            5'd20: op = '{A_DIR, 2'd2, B_Q,   2'd2, 1'b0, 1'b0, D_NV,   2'd0};
            5'd21: op = '{A_E2,  2'd0, B_Q,   2'd0, 1'b0, 1'b1, D_NONE, 2'd0};
            5'd22: op = '{A_E2,  2'd1, B_Q,   2'd1, 1'b0, 1'b0, D_NONE, 2'd0};
            5'd23: op = '{A_E2,  2'd2, B_Q,   2'd2, 1'b0, 1'b0, D_NT,   2'd0};
            5'd24: op = '{A_TOL, 2'd0, B_DET, 2'd0, 1'b0, 1'b1, D_LO,   2'd0};
            default: op = '{A_TOL, 2'd0, B_DET, 2'd0, 1'b0, 1'b1, D_NONE, 2'd0};
        endcase
        return op;
    endfunction

endpackage

@@ rtl/ray_triangle_hit_counter_top.sv @@
// Top level of the ray/triangle hit counter.
// Each request carries one triangle; the block answers with a hit flag and the saturating hit
// count of the current run, which clears after the request marked tlast. All products are
// exact and run on one shared 33-bit by 33-bit signed multiplier, one 32-bit digit per cycle.
// An item takes 25 products, only nine when the determinant is rejected as near zero. A new
// request is taken as soon as the previous result sits in the output register.
module ray_triangle_hit_counter_top
    import rthc_pkg::*;
#(
    parameter int COORD_BITS = 32,
    parameter int FRAC_BITS  = 16,
    parameter int COUNT_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // ax, ay, az, bx, by_coord, bz, cx, cy, cz
    input  logic [((9*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
    input  logic                  s_axis_tlast,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // hit, hit_total
    output logic [((COUNT_BITS+8)/8)*8-1:0] m_axis_tdata,
    output logic                  m_axis_tlast,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [COORD_BITS-1:0] cfg_wdata
);

    localparam int OUT_W = ((COUNT_BITS + 8) / 8) * 8;

    cmd_t                  cmd;
    logic                  det_small;
    logic                  hit;
    logic [COUNT_BITS-1:0] hit_total;

    rthc_ctrl #(
        .COORD_BITS(COORD_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_valid   (s_axis_tvalid),
        .s_ready   (s_axis_tready),
        .m_valid   (m_axis_tvalid),
        .m_ready   (m_axis_tready),
        .det_small (det_small),
        .cmd       (cmd)
    );

    rthc_dp #(
        .COORD_BITS(COORD_BITS),
        .FRAC_BITS (FRAC_BITS),
        .COUNT_BITS(COUNT_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .tri_data  (s_axis_tdata[9*COORD_BITS-1:0]),
        .tri_last  (s_axis_tlast),
        .cmd       (cmd),
        .det_small (det_small),
        .hit       (hit),
        .hit_total (hit_total),
        .last_out  (m_axis_tlast)
    );

    assign m_axis_tdata = OUT_W'({hit_total, hit});

endmodule

@@ rtl/rthc_ctrl.sv @@
// Controller: sequences the product schedule, the determinant test and the result handoff.
module rthc_ctrl
    import rthc_pkg::*;
#(
    parameter int COORD_BITS = 32
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_valid,
    output logic s_ready,
    output logic m_valid,
    input  logic m_ready,
    input  logic det_small,
    output cmd_t cmd
);

    localparam int EW  = COORD_BITS + 1;
    localparam int HW  = 2 * COORD_BITS + 3;
    localparam int DDW = 3 * COORD_BITS + 6;
    localparam int NDE = (EW + DIGIT_W - 1) / DIGIT_W;
    localparam int NDH = (HW + DIGIT_W - 1) / DIGIT_W;
    localparam int NDD = (DDW + DIGIT_W - 1) / DIGIT_W;

    state_t               state_reg, state_next;
    logic [STEP_W-1:0]    step_reg, step_next;
    logic [DIG_IDX_W-1:0] dig_reg, dig_next;
    logic                 out_valid_reg, out_valid_next;
    op_t                  op_cur, op_nxt;
    op_t                  op_first, op_nu, op_lo;

    function automatic logic [DIG_IDX_W-1:0] top_dig(input b_grp_t g);
        logic [DIG_IDX_W-1:0] r;
        case (g)
            B_E1, B_E2: r = DIG_IDX_W'(NDE - 1);
            B_H, B_Q:   r = DIG_IDX_W'(NDH - 1);
            default:    r = DIG_IDX_W'(NDD - 1);
        endcase
        return r;
    endfunction

    assign op_cur   = op_of(step_reg);
    assign op_nxt   = op_of(step_reg + STEP_W'(1));
    assign op_first = op_of(STEP_FIRST);
    assign op_nu    = op_of(STEP_NU_START);
    assign op_lo    = op_of(STEP_LO);
    assign m_valid  = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            dig_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            dig_reg       <= dig_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        dig_next   = dig_reg;
        s_ready    = 1'b0;
        cmd        = '0;
        cmd.step   = step_reg;
        cmd.dig    = dig_reg;
        cmd.top    = (dig_reg == top_dig(op_cur.b_grp));
        case (state_reg)
            ST_IDLE:
            begin
                s_ready = 1'b1;
                if (s_valid)
                begin
                    cmd.load   = 1'b1;
                    step_next  = STEP_FIRST;
                    dig_next   = top_dig(op_first.b_grp);
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul = 1'b1;
                if (dig_reg == '0)
                    state_next = ST_ACC;
                else
                    dig_next = dig_reg - DIG_IDX_W'(1);
            end
            ST_ACC:
            begin
                cmd.acc = 1'b1;
                if (step_reg == STEP_DET_END)
                    state_next = ST_DET;
                else if (step_reg == STEP_NT_END)
                    state_next = ST_FIX;
                else if (step_reg == STEP_LO)
                    state_next = ST_CHK;
                else
                begin
                    step_next  = step_reg + STEP_W'(1);
                    dig_next   = top_dig(op_nxt.b_grp);
                    state_next = ST_MUL;
                end
            end
            ST_DET:
            begin
                if (det_small)
                begin
                    cmd.miss   = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    step_next  = STEP_NU_START;
                    dig_next   = top_dig(op_nu.b_grp);
                    state_next = ST_MUL;
                end
            end
            ST_FIX:
            begin
                cmd.fix    = 1'b1;
                step_next  = STEP_LO;
                dig_next   = top_dig(op_lo.b_grp);
                state_next = ST_MUL;
            end
            ST_CHK:
            begin
                cmd.chk    = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_ready)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.emit)
            out_valid_next = 1'b1;
        else if (m_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

endmodule

@@ rtl/rthc_dp.sv @@
// Datapath: ray registers, edge vectors, digit-serial multiply-accumulate, bound tests, hit count.
module rthc_dp
    import rthc_pkg::*;
#(
    parameter int COORD_BITS = 32,
    parameter int FRAC_BITS  = 16,
    parameter int COUNT_BITS = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]    cfg_addr,
    input  logic [COORD_BITS-1:0]   cfg_wdata,
    input  logic [9*COORD_BITS-1:0] tri_data,
    input  logic                    tri_last,
    input  cmd_t                    cmd,
    output logic                    det_small,
    output logic                    hit,
    output logic [COUNT_BITS-1:0]   hit_total,
    output logic                    last_out
);

    localparam int C   = COORD_BITS;
    localparam int EW  = C + 1;
    localparam int HW  = 2 * C + 3;
    localparam int DDW = 3 * C + 6;
    localparam int LW  = DDW + TOL_W + 1;
    localparam int NDD = (DDW + DIGIT_W - 1) / DIGIT_W;
    localparam int BW  = NDD * DIGIT_W;
    localparam int PRW = EW + DIGIT_W + 1;
    localparam int PW  = EW + BW + 1;
    localparam int SH  = 2 * FRAC_BITS;
    localparam int CW  = DDW + SH + 3;
    localparam logic [C-1:0] DIR_X_RESET = C'(1) << FRAC_BITS;

    logic signed [C-1:0]    org_reg [3];
    logic signed [C-1:0]    dir_reg [3];
    logic [TOL_W-1:0]       tol_reg;
    logic signed [EW-1:0]   e1_reg [3];
    logic signed [EW-1:0]   e2_reg [3];
    logic signed [EW-1:0]   sv_reg [3];
    logic signed [HW-1:0]   h_reg [3];
    logic signed [HW-1:0]   q_reg [3];
    logic signed [DDW-1:0]  det_reg, nu_reg, nv_reg, nt_reg;
    logic signed [LW-1:0]   lo_reg;
    logic signed [PW-1:0]   term_reg, acc_reg;
    logic                   last_reg, hit_reg;
    logic [COUNT_BITS-1:0]  run_hits_reg;
    logic                   hit_out_reg, last_out_reg;
    logic [COUNT_BITS-1:0]  total_reg;

    logic signed [C-1:0]    vtx [9];
    op_t                    op;
    logic signed [EW-1:0]   a_bus;
    logic signed [BW-1:0]   b_bus;
    logic [DIGIT_W-1:0]     dig_bits;
    logic signed [DIGIT_W:0] dig_s;
    logic signed [PRW-1:0]  prod;
    logic signed [PW-1:0]   term_next, acc_base, acc_sum;
    logic signed [DDW-1:0]  band;
    logic signed [CW-1:0]   nu_w, nv_w, nuv_w, nt_w, lo_w, hi_w;
    logic                   hit_ok;
    logic [COUNT_BITS-1:0]  cnt_next;

    always_comb
    begin
        for (int i = 0; i < 9; i++)
            vtx[i] = tri_data[i*C +: C];
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                org_reg[i] <= '0;
                dir_reg[i] <= '0;
            end
            dir_reg[0] <= DIR_X_RESET;
            tol_reg    <= TOL_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                REG_ORIGIN_X: org_reg[0] <= cfg_wdata;
                REG_ORIGIN_Y: org_reg[1] <= cfg_wdata;
                REG_ORIGIN_Z: org_reg[2] <= cfg_wdata;
                REG_DIR_X:    dir_reg[0] <= cfg_wdata;
                REG_DIR_Y:    dir_reg[1] <= cfg_wdata;
                REG_DIR_Z:    dir_reg[2] <= cfg_wdata;
                REG_TOL:      tol_reg    <= cfg_wdata[TOL_W-1:0];
                default:      ;
            endcase
        end
    end

    assign op = op_of(cmd.step);

    always_comb
    begin
        case (op.a_grp)
            A_DIR:   a_bus = EW'(dir_reg[op.a_idx]);
            A_E1:    a_bus = e1_reg[op.a_idx];
            A_E2:    a_bus = e2_reg[op.a_idx];
            A_SV:    a_bus = sv_reg[op.a_idx];
            default: a_bus = EW'($signed({1'b0, tol_reg}));
        endcase
        case (op.b_grp)
            B_E1:    b_bus = BW'(e1_reg[op.b_idx]);
            B_E2:    b_bus = BW'(e2_reg[op.b_idx]);
            B_H:     b_bus = BW'(h_reg[op.b_idx]);
            B_Q:     b_bus = BW'(q_reg[op.b_idx]);
            default: b_bus = BW'(det_reg);
        endcase
    end

    // most significant digit first; only the top digit carries the sign
    assign dig_bits  = b_bus[cmd.dig*DIGIT_W +: DIGIT_W];
    assign dig_s     = $signed({cmd.top & dig_bits[DIGIT_W-1], dig_bits});
    assign prod      = a_bus * dig_s;
    assign term_next = cmd.top ? PW'(prod) : (term_reg <<< DIGIT_W) + PW'(prod);
    assign acc_base  = op.first ? '0 : acc_reg;
    assign acc_sum   = op.neg ? acc_base - term_reg : acc_base + term_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            for (int i = 0; i < 3; i++)
            begin
                e1_reg[i] <= EW'(vtx[3+i]) - EW'(vtx[i]);
                e2_reg[i] <= EW'(vtx[6+i]) - EW'(vtx[i]);
                sv_reg[i] <= EW'(org_reg[i]) - EW'(vtx[i]);
            end
            last_reg <= tri_last;
        end
        if (cmd.mul)
            term_reg <= term_next;
        if (cmd.acc)
        begin
            acc_reg <= acc_sum;
            case (op.d_grp)
                D_H:     h_reg[op.d_idx] <= HW'(acc_sum);
                D_Q:     q_reg[op.d_idx] <= HW'(acc_sum);
                D_DET:   det_reg <= DDW'(acc_sum);
                D_NU:    nu_reg  <= DDW'(acc_sum);
                D_NV:    nv_reg  <= DDW'(acc_sum);
                D_NT:    nt_reg  <= DDW'(acc_sum);
                D_LO:    lo_reg  <= LW'(acc_sum);
                default: ;
            endcase
        end
        if (cmd.fix && det_reg < 0)
        begin
            det_reg <= -det_reg;
            nu_reg  <= -nu_reg;
            nv_reg  <= -nv_reg;
            nt_reg  <= -nt_reg;
        end
        if (cmd.chk)
            hit_reg <= hit_ok;
        else if (cmd.miss)
            hit_reg <= 1'b0;
    end

    assign band      = $signed(DDW'({1'b0, tol_reg}) << FRAC_BITS);
    assign det_small = (det_reg < band) && (det_reg > -band);

    assign nu_w  = CW'(nu_reg) <<< SH;
    assign nv_w  = CW'(nv_reg) <<< SH;
    assign nuv_w = (CW'(nu_reg) + CW'(nv_reg)) <<< SH;
    assign nt_w  = CW'(nt_reg) <<< SH;
    assign lo_w  = CW'(lo_reg);
    assign hi_w  = (CW'(det_reg) <<< SH) + lo_w;

    assign hit_ok = !(nu_w < -lo_w) && !(nu_w > hi_w) && !(nv_w < -lo_w)
                    && !(nuv_w > hi_w) && (nt_w > lo_w);

    assign cnt_next = (hit_reg && run_hits_reg != '1) ? run_hits_reg + COUNT_BITS'(1)
                                                      : run_hits_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            run_hits_reg <= '0;
        else if (cmd.emit)
            run_hits_reg <= last_reg ? '0 : cnt_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            hit_out_reg  <= hit_reg;
            total_reg    <= cnt_next;
            last_out_reg <= last_reg;
        end
    end

    assign hit       = hit_out_reg;
    assign hit_total = total_reg;
    assign last_out  = last_out_reg;

endmodule

@@ rtl/rthc_checker.sv @@
// Port-level checks for the ray/triangle hit counter, bound to the top level.
module rthc_checker #(
    parameter int COUNT_BITS = 16
) (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 s_axis_tvalid,
    input logic                                 s_axis_tready,
    input logic                                 m_axis_tvalid,
    input logic                                 m_axis_tready,
    input logic [((COUNT_BITS+8)/8)*8-1:0]      m_axis_tdata,
    input logic                                 m_axis_tlast
);

    // one request in flight at a time
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request taken while another is in work");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled result changed");

    a_hit_counted: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[COUNT_BITS:1] != '0)
        else $error("hit reported with zero run total");

endmodule

bind ray_triangle_hit_counter_top rthc_checker #(.COUNT_BITS(COUNT_BITS)) u_rthc_checker (.*);

@@ tb/sv/ray_triangle_hit_checker.sv @@
// Scoreboard for the ray/triangle hit counter: predicts each result and compares it.
module ray_triangle_hit_checker
    import rthc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    input  logic                 s_axis_tready,
    input  logic [287:0]         s_axis_tdata,
    input  logic                 s_axis_tlast,
    input  logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    input  logic [23:0]          m_axis_tdata,
    input  logic                 m_axis_tlast,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [31:0]          cfg_wdata,
    output int                   fail_count,
    output int                   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [255:0] wide_t;

    typedef struct {
        logic        hit;
        logic [15:0] total;
        logic        last;
    } hit_result_t;

    logic [31:0] org [3];
    logic [31:0] dir [3];
    logic [15:0] tol;
    logic [15:0] run_hits;
    hit_result_t result_q [$];

    function automatic wide_t sx(input logic [31:0] v);
        wide_t w;
        w = $signed(v);
        return w;
    endfunction

    function automatic wide_t dot3(input wide_t a [3], input wide_t b [3]);
        return a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
    endfunction

    function automatic logic ray_hits(input logic [287:0] data);
        wide_t va [3], vb [3], vc [3], o [3], d [3];
        wide_t e1 [3], e2 [3], h [3], s [3], q [3];
        wide_t det, nu, nv, nt, band, sc, tl, lo, hi;
        for (int i = 0; i < 3; i++)
        begin
            va[i] = sx(data[32*i +: 32]);
            vb[i] = sx(data[32*(3+i) +: 32]);
            vc[i] = sx(data[32*(6+i) +: 32]);
            o[i]  = sx(org[i]);
            d[i]  = sx(dir[i]);
            e1[i] = vb[i] - va[i];
            e2[i] = vc[i] - va[i];
            s[i]  = o[i] - va[i];
        end
        h[0] = d[1] * e2[2] - d[2] * e2[1];
        h[1] = d[2] * e2[0] - d[0] * e2[2];
        h[2] = d[0] * e2[1] - d[1] * e2[0];
        det  = dot3(e1, h);
        band = {240'd0, tol} <<< 16;
        if (det < band && det > -band)
            return 1'b0;
        q[0] = s[1] * e1[2] - s[2] * e1[1];
        q[1] = s[2] * e1[0] - s[0] * e1[2];
        q[2] = s[0] * e1[1] - s[1] * e1[0];
        nu = dot3(s, h);
        nv = dot3(d, q);
        nt = dot3(e2, q);
        if (det < 0)
        begin
            det = -det;
            nu  = -nu;
            nv  = -nv;
            nt  = -nt;
        end
        sc = wide_t'(1) <<< 32;
        tl = {240'd0, tol};
        lo = tl * det;
        hi = (sc + tl) * det;
        if (nu * sc < -lo || nu * sc > hi)
            return 1'b0;
        if (nv * sc < -lo || (nu + nv) * sc > hi)
            return 1'b0;
        return nt * sc > lo;
    endfunction

    assign pending = result_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        hit_result_t r;
        hit_result_t got;
        if (!rst_n)
        begin
            org[0] = '0; org[1] = '0; org[2] = '0;
            dir[0] = 32'h0001_0000; dir[1] = '0; dir[2] = '0;
            tol = TOL_RESET;
            run_hits = '0;
            fail_count = 0;
            result_q.delete();
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.hit   = m_axis_tdata[0];
                got.total = m_axis_tdata[16:1];
                got.last  = m_axis_tlast;
                if (result_q.size() == 0)
                begin
                    $error("result with nothing expected: hit=%0d hit_total=%0d",
                           got.hit, got.total);
                    fail_count++;
                end
                else
                begin
                    r = result_q.pop_front();
                    if (got.hit !== r.hit)
                    begin
                        $error("hit: expected %0d, got %0d", r.hit, got.hit);
                        fail_count++;
                    end
                    if (got.total !== r.total)
                    begin
                        $error("hit_total: expected %0d, got %0d", r.total, got.total);
                        fail_count++;
                    end
                    if (got.last !== r.last)
                    begin
                        $error("last_out: expected %0d, got %0d", r.last, got.last);
                        fail_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                r.hit = ray_hits(s_axis_tdata);
                if (r.hit && run_hits != 16'hFFFF)
                    run_hits++;
                r.total = run_hits;
                r.last  = s_axis_tlast;
                if (s_axis_tlast)
                    run_hits = '0;
                result_q.push_back(r);
            end
            if (cfg_wr_en)
            begin
                case (cfg_addr)
                    REG_ORIGIN_X: org[0] = cfg_wdata;
                    REG_ORIGIN_Y: org[1] = cfg_wdata;
                    REG_ORIGIN_Z: org[2] = cfg_wdata;
                    REG_DIR_X:    dir[0] = cfg_wdata;
                    REG_DIR_Y:    dir[1] = cfg_wdata;
                    REG_DIR_Z:    dir[2] = cfg_wdata;
                    REG_TOL:      tol    = cfg_wdata[15:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

@@ tb/sv/tb_top.sv @@
// Testbench top for the ray/triangle hit counter: stimulus, configuration and verdict.
module tb_top;
    import rthc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int Q1 = 65536;

    typedef struct {
        logic [31:0] v [9];
        logic        last;
    } triangle_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [287:0]         s_axis_tdata = '0;
    logic                 s_axis_tlast = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [23:0]          m_axis_tdata;
    logic                 m_axis_tlast;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_addr = '0;
    logic [31:0]          cfg_wdata = '0;
    int                   fail_count;
    int                   pending;
    logic                 idle_on = 1'b1;
    int                   results_seen = 0;
    logic signed [31:0]   org [3];
    logic signed [31:0]   dir [3];

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    ray_triangle_hit_counter_top i_dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    ray_triangle_hit_checker i_checker (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .fail_count(fail_count), .pending(pending)
    );

    // receiver: random holds, one long hold to back the pipeline up
    initial
    begin
        int n;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (results_seen == 200)
                n = 3000;
            else
                n = idle_on ? $urandom_range(0, 5) : 0;
            if (n > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (n) @(negedge clk);
                m_axis_tready <= 1'b1;
            end
            else
                m_axis_tready <= 1'b1;
            do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
            results_seen++;
            @(negedge clk);
        end
    end

    task automatic send_triangle(input triangle_t t);
        int n;
        n = idle_on ? $urandom_range(0, 5) : 0;
        if (n > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (n) @(negedge clk);
        end
        s_axis_tdata  <= {t.v[8], t.v[7], t.v[6], t.v[5], t.v[4], t.v[3], t.v[2], t.v[1], t.v[0]};
        s_axis_tlast  <= t.last;
        s_axis_tvalid <= 1'b1;
        do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
        @(negedge clk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (100) @(negedge clk);
    endtask

    task automatic cfg_set(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(negedge clk);
    endtask

    task automatic load_ray(input logic [31:0] o [3], input logic [31:0] d [3],
                            input logic [15:0] tol);
        cfg_set(REG_ORIGIN_X, o[0]);
        cfg_set(REG_ORIGIN_Y, o[1]);
        cfg_set(REG_ORIGIN_Z, o[2]);
        cfg_set(REG_DIR_X, d[0]);
        cfg_set(REG_DIR_Y, d[1]);
        cfg_set(REG_DIR_Z, d[2]);
        cfg_set(REG_TOL, {16'($urandom_range(0, 16'hFFFF)), tol});
        cfg_set(3'd7, $urandom());
        cfg_wr_en <= 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            org[i] = o[i];
            dir[i] = d[i];
        end
    endtask

    function automatic triangle_t make_tri(input int a0, input int a1, input int a2,
                                           input int b0, input int b1, input int b2,
                                           input int c0, input int c1, input int c2,
                                           input logic last);
        triangle_t t;
        t.v[0] = a0; t.v[1] = a1; t.v[2] = a2;
        t.v[3] = b0; t.v[4] = b1; t.v[5] = b2;
        t.v[6] = c0; t.v[7] = c1; t.v[8] = c2;
        t.last = last;
        return t;
    endfunction

    // triangle around a point on the ray line, plus noise and degenerate shapes
    function automatic triangle_t random_tri();
        triangle_t t;
        longint k, p, span;
        int pick;
        pick = $urandom_range(0, 9);
        t.last = ($urandom_range(0, 7) == 0);
        if (pick < 7)
        begin
            k = longint'($urandom_range(1, 1 << 18));
            if ($urandom_range(0, 9) == 0)
                k = -k;
            span = longint'(1) << $urandom_range(4, 20);
            for (int i = 0; i < 3; i++)
            begin
                p = longint'(org[i]) + ((longint'(dir[i]) * k) >>> 16);
                for (int j = 0; j < 3; j++)
                    t.v[3*j+i] = 32'(p + longint'($urandom_range(0, 32'(2 * span))) - span);
            end
        end
        else if (pick < 9)
        begin
            for (int i = 0; i < 9; i++)
                t.v[i] = $urandom();
        end
        else
        begin
            for (int i = 0; i < 3; i++)
            begin
                t.v[i]   = $urandom();
                t.v[3+i] = $urandom_range(0, 1) ? t.v[i] : $urandom();
                t.v[6+i] = t.v[3+i];
            end
        end
        return t;
    endfunction

    task automatic send_directed(input logic last_all);
        int mx, mn;
        mx = 32'h7FFF_FFFF;
        mn = 32'h8000_0000;
        send_triangle(make_tri(Q1, -Q1, -Q1, Q1, 2*Q1, -Q1, Q1, -Q1, 2*Q1, 0));
        send_triangle(make_tri(-Q1, -Q1, -Q1, -Q1, 2*Q1, -Q1, -Q1, -Q1, 2*Q1, 0));
        send_triangle(make_tri(Q1, 0, 0, Q1, Q1, 0, Q1, 0, Q1, 0));
        send_triangle(make_tri(Q1, 0, -Q1, Q1, Q1, 0, Q1, 0, Q1, 0));
        send_triangle(make_tri(Q1, Q1, Q1, Q1, 2*Q1, Q1, Q1, Q1, 2*Q1, 0));
        send_triangle(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_triangle(make_tri(0, Q1, 0, Q1, Q1, 0, 0, Q1, Q1, 0));
        send_triangle(make_tri(4, -1, -1, 4, 1, -1, 4, -1, 1, 0));
        send_triangle(make_tri(mx, mx, mx, mx, mx, mx, mx, mx, mx, 0));
        send_triangle(make_tri(mn, mn, mn, mn, mn, mn, mn, mn, mn, 0));
        send_triangle(make_tri(mx, mn, mn, mx, mx, mn, mx, mn, mx, 0));
        send_triangle(make_tri(mn, mx, mx, mx, mn, mx, mx, mx, mn, last_all));
        send_triangle(make_tri(3*Q1, -Q1, -Q1, 3*Q1, -Q1, 2*Q1, 3*Q1, 2*Q1, -Q1, 1));
        send_triangle(make_tri(Q1, -Q1, -Q1, Q1, -Q1, 2*Q1, Q1, 2*Q1, -Q1, 1));
    endtask

    initial
    begin
        logic [31:0] o [3];
        logic [31:0] d [3];
        logic [15:0] tol;
        int n;
        org[0] = 0; org[1] = 0; org[2] = 0;
        dir[0] = Q1; dir[1] = 0; dir[2] = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        send_directed(1'b0);
        for (int ph = 0; ph < 14; ph++)
        begin
            wait_drained();
            for (int i = 0; i < 3; i++)
            begin
                o[i] = $urandom_range(0, 1 << 21) - (1 << 20);
                d[i] = $urandom_range(0, 1 << 18) - (1 << 17);
            end
            tol = 16'($urandom_range(0, 64));
            case (ph)
                0: begin o = '{0, 0, 0}; d = '{Q1, 0, 0}; tol = 16'd0; end
                1: begin o = '{0, 0, 0}; d = '{Q1, 0, 0}; tol = 16'hFFFF; end
                2: begin o = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
                         d = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000}; end
                3: d = '{0, 0, -Q1};
                4: tol = 16'($urandom());
                default: ;
            endcase
            load_ray(o, d, tol);
            idle_on = (ph != 6);
            if (ph < 2)
                send_directed(1'b1);
            n = (ph < 2) ? 20 : 89;
            repeat (n) send_triangle(random_tri());
        end
        wait_drained();
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #10ms;
        $display("== FAIL ==");
        $finish;
    end

endmodule

@@ ray_triangle_hit_counter_top.f @@
rtl/rthc_pkg.sv
rtl/rthc_ctrl.sv
rtl/rthc_dp.sv
rtl/ray_triangle_hit_counter_top.sv
rtl/rthc_checker.sv
tb/sv/ray_triangle_hit_checker.sv
tb/sv/tb_top.sv
